FILE: rtl/cdg_pkg.sv
// ----------------------------------------------------------------------------
// Cosine distance package
// Shared types, constants and saturation helper for the cosine distance block.
// ----------------------------------------------------------------------------
package cdg_pkg;

  localparam int SUM_W   = 48;
  localparam int RAD_W   = 96;
  localparam int NUM_W   = 72;
  localparam int SUB_W   = 50;
  localparam int QUO_W   = 34;
  localparam int MUL_XW  = 33;
  localparam int MUL_YW  = 25;
  localparam int MUL_PW  = 58;
  localparam int ACC_W   = 80;

  localparam logic [17:0] ONE_Q16 = 18'd65536;

  localparam logic [6:0] MUL_LAST   = 7'd3;
  localparam logic [6:0] PMUL_LAST  = 7'd4;
  localparam logic [6:0] SQRT_LAST  = 7'd47;
  localparam logic [6:0] DIV_LAST   = 7'd71;
  localparam logic [6:0] GMUL_LAST  = 7'd10;
  localparam logic [6:0] GMUL_HALF  = 7'd5;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SLOT,
    S_MUL,
    S_FWD_END,
    S_RD,
    S_LOAD,
    S_PMUL,
    S_SQRT,
    S_DSET,
    S_DIV,
    S_DEND,
    S_GMUL,
    S_DONE
  } cdg_state_t;

  typedef enum logic [1:0] {
    DIV_COS,
    DIV_ALPHA,
    DIV_K1,
    DIV_K2
  } cdg_div_sel_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] norm_a;
    logic signed [SUM_W-1:0] norm_b;
    logic signed [SUM_W-1:0] dot;
  } cdg_sums_t;

  function automatic logic signed [31:0] sat_q(input logic [43:0] mag, input logic neg);
    logic signed [31:0] res;
    if (neg) begin
      if (mag >= 44'h0_8000_0000) begin
        res = 32'sh8000_0000;
      end else begin
        res = -$signed(mag[31:0]);
      end
    end else begin
      if (mag > 44'h0_7FFF_FFFF) begin
        res = 32'sh7FFF_FFFF;
      end else begin
        res = $signed(mag[31:0]);
      end
    end
    return res;
  endfunction

endpackage

FILE: rtl/cdg_if.sv
// ----------------------------------------------------------------------------
// Cosine distance channels
// Valid/ready channel interfaces for feature pairs and results.
// ----------------------------------------------------------------------------
interface cdg_in_if;
  logic               valid;
  logic               ready;
  logic               mode;
  logic [5:0]         sample_index;
  logic signed [15:0] feature_a;
  logic signed [15:0] feature_b;
  logic               last_element;
  logic signed [31:0] upstream_grad;

  modport source (output valid, mode, sample_index, feature_a, feature_b, last_element,
                  upstream_grad, input ready);
  modport sink (input valid, mode, sample_index, feature_a, feature_b, last_element,
                upstream_grad, output ready);
endinterface

interface cdg_out_if;
  logic               valid;
  logic               ready;
  logic               result_kind;
  logic [5:0]         sample_out;
  logic [17:0]        distance;
  logic signed [31:0] grad_a;
  logic signed [31:0] grad_b;
  logic               degenerate;
  logic               last_out;

  modport source (output valid, result_kind, sample_out, distance, grad_a, grad_b,
                  degenerate, last_out, input ready);
  modport sink (input valid, result_kind, sample_out, distance, grad_a, grad_b,
                degenerate, last_out, output ready);
endinterface

FILE: rtl/cosine_distance_with_gradient_top.sv
// ----------------------------------------------------------------------------
// Cosine distance with gradient
// Forward cosine distance and backward gradients over streamed feature pairs.
// ----------------------------------------------------------------------------
// One transaction is taken at a time; in_ch.ready is high only when the
// sequencer is idle, and a finished result waits in the output register while
// the next transaction is taken. Every product goes through one shared 33x25
// multiplier, and the square root and all divisions go bit by bit through one
// shared 50-bit subtractor. A forward element that is not last takes four
// multiplier steps. A forward last element with non-degenerate norms adds
// the norm product (5 steps), a 48-step root and a 72-step divide. A backward
// element of a non-degenerate sample takes eleven multiplier steps; the first
// one of a sample also reads the stored sums and runs the norm product, the
// root and three divides. Indexes at or above MAX_SAMPLES are reduced by repeated
// subtraction of MAX_SAMPLES before use. The per-sample store has no reset.
module cosine_distance_with_gradient_top
  import cdg_pkg::*;
#(
  parameter int MAX_SAMPLES = 64
) (
  input  logic          clk,
  input  logic          rst_n,
  cdg_in_if.sink        in_ch,
  cdg_out_if.source     out_ch
);

  localparam int SLOT_W = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;

  cdg_state_t   state_r, state_nxt;
  cdg_div_sel_t div_sel_r;
  logic [6:0]   step_r;

  logic               mode_r, last_r, start_r, at_start_r;
  logic [5:0]         sidx_r, idx_r;
  logic signed [15:0] a_r, b_r;
  logic signed [31:0] g_r;

  logic signed [SUM_W-1:0] sum_aa_r, sum_bb_r, sum_ab_r;
  logic signed [SUM_W-1:0] n1_r, n2_r, d_r;

  cdg_sums_t mem_r [MAX_SAMPLES];
  cdg_sums_t rd_r;
  logic      mem_we;

  logic signed [MUL_XW-1:0] mul_x;
  logic signed [MUL_YW-1:0] mul_y;
  logic signed [MUL_PW-1:0] mul_r;

  logic [SUB_W-1:0] sub_a, sub_b;
  logic [SUB_W:0]   sub_full;
  logic             sub_ge;

  logic [RAD_W-1:0] rad_r;
  logic [SUM_W-1:0] rem_r, root_r, den_r;
  logic [NUM_W-1:0] num_r;
  logic [QUO_W-1:0] q_r;
  logic             ovf_r, dneg_div_r;

  logic [31:0]        amag_r;
  logic               aneg_r;
  logic signed [31:0] k1_r, k2_r;
  logic               bwd_deg_r, fdeg_r;
  logic [17:0]        dist_r;
  logic [SUM_W-1:0]   dmag_r;
  logic               dneg_r;
  logic [ACC_W-1:0]   acc_r;
  logic signed [31:0] ga_r, gb_r;

  logic               out_valid_r, out_kind_r, out_deg_r, out_last_r;
  logic [5:0]         out_sidx_r;
  logic [17:0]        out_dist_r;
  logic signed [31:0] out_ga_r, out_gb_r;

  logic               in_acc, out_load, slot_hi, fwd_deg, rd_deg;
  logic [SLOT_W-1:0]  slot;
  logic               g_first;
  logic [2:0]         g_ph;
  logic signed [15:0] g_x, g_y;
  logic signed [31:0] g_k;
  logic signed [MUL_PW-1:0] g_diff;
  logic [49:0]        rem_sh_sq;
  logic [48:0]        rem_sh_dv;
  logic [SUM_W-1:0]   d_mag;
  logic [31:0]        g_mag;
  logic [43:0]        q_mag;
  logic signed [31:0] q_fac;
  logic [16:0]        c_mag;

  function automatic logic signed [SUM_W-1:0] sat_add(input logic signed [SUM_W-1:0] s,
                                                      input logic signed [MUL_PW-1:0] p);
    logic [SUM_W:0] s49;
    logic signed [SUM_W-1:0] res;
    s49 = {s[SUM_W-1], s} + p[SUM_W:0];
    if (s49[SUM_W] != s49[SUM_W-1]) begin
      res = s49[SUM_W] ? 48'sh8000_0000_0000 : 48'sh7FFF_FFFF_FFFF;
    end else begin
      res = s49[SUM_W-1:0];
    end
    return res;
  endfunction

  function automatic logic is_deg(input logic signed [SUM_W-1:0] x,
                                  input logic signed [SUM_W-1:0] y);
    return x[SUM_W-1] || (x == '0) || y[SUM_W-1] || (y == '0);
  endfunction

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && (state_r == S_IDLE);
  assign out_load    = (state_r == S_DONE) && (!out_valid_r || out_ch.ready);
  assign slot_hi     = (11'(idx_r) >= 11'(MAX_SAMPLES));
  assign slot        = SLOT_W'(idx_r);
  assign fwd_deg     = is_deg(sum_aa_r, sum_bb_r);
  assign rd_deg      = is_deg(rd_r.norm_a, rd_r.norm_b);
  assign mem_we      = (state_r == S_FWD_END);

  assign g_first = (step_r < GMUL_HALF);
  assign g_ph    = g_first ? step_r[2:0] : 3'(step_r - GMUL_HALF);
  assign g_x     = g_first ? a_r : b_r;
  assign g_y     = g_first ? b_r : a_r;
  assign g_k     = g_first ? k1_r : k2_r;
  assign g_diff  = {{18{g_y[15]}}, g_y, 24'd0} - mul_r;

  assign rem_sh_sq = {rem_r, rad_r[RAD_W-1 -: 2]};
  assign rem_sh_dv = {rem_r, num_r[NUM_W-1]};
  assign d_mag     = d_r[SUM_W-1] ? SUM_W'(-d_r) : SUM_W'(d_r);
  assign g_mag     = g_r[31] ? 32'(-g_r) : 32'(g_r);
  assign q_mag     = ovf_r ? '1 : {10'd0, q_r};
  assign q_fac     = sat_q(q_mag, dneg_div_r);
  assign c_mag     = (ovf_r || (q_r > QUO_W'(ONE_Q16))) ? 17'h10000 : q_r[16:0];

  assign sub_full = {1'b0, sub_a} - {1'b0, sub_b};
  assign sub_ge   = !sub_full[SUB_W];

  always_comb begin
    state_nxt = state_r;
    mul_x     = '0;
    mul_y     = '0;
    sub_a     = '0;
    sub_b     = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) state_nxt = S_SLOT;
      end
      S_SLOT: begin
        priority if (slot_hi) state_nxt = S_SLOT;
        else if (!mode_r) state_nxt = S_MUL;
        else if (start_r) state_nxt = S_RD;
        else if (bwd_deg_r) state_nxt = S_DONE;
        else state_nxt = S_GMUL;
      end
      S_MUL: begin
        unique case (step_r[1:0])
          2'd0: begin
            mul_x = {{17{a_r[15]}}, a_r};
            mul_y = {{9{a_r[15]}}, a_r};
          end
          2'd1: begin
            mul_x = {{17{b_r[15]}}, b_r};
            mul_y = {{9{b_r[15]}}, b_r};
          end
          2'd2: begin
            mul_x = {{17{a_r[15]}}, a_r};
            mul_y = {{9{b_r[15]}}, b_r};
          end
          default: begin
          end
        endcase
        if (step_r == MUL_LAST) state_nxt = last_r ? S_FWD_END : S_IDLE;
      end
      S_FWD_END: state_nxt = fwd_deg ? S_DONE : S_PMUL;
      S_RD:      state_nxt = S_LOAD;
      S_LOAD:    state_nxt = rd_deg ? S_DONE : S_PMUL;
      S_PMUL: begin
        unique case (step_r[2:0])
          3'd0: begin
            mul_x = {9'd0, n1_r[23:0]};
            mul_y = {1'b0, n2_r[23:0]};
          end
          3'd1: begin
            mul_x = {9'd0, n1_r[23:0]};
            mul_y = {1'b0, n2_r[47:24]};
          end
          3'd2: begin
            mul_x = {9'd0, n1_r[47:24]};
            mul_y = {1'b0, n2_r[23:0]};
          end
          3'd3: begin
            mul_x = {9'd0, n1_r[47:24]};
            mul_y = {1'b0, n2_r[47:24]};
          end
          default: begin
          end
        endcase
        if (step_r == PMUL_LAST) state_nxt = S_SQRT;
      end
      S_SQRT: begin
        sub_a = rem_sh_sq;
        sub_b = {root_r, 2'b01};
        if (step_r == SQRT_LAST) state_nxt = S_DSET;
      end
      S_DSET: state_nxt = S_DIV;
      S_DIV: begin
        sub_a = {1'b0, rem_sh_dv};
        sub_b = {2'b00, den_r};
        if (step_r == DIV_LAST) state_nxt = S_DEND;
      end
      S_DEND: begin
        unique case (div_sel_r)
          DIV_COS:   state_nxt = S_DONE;
          DIV_K2:    state_nxt = S_GMUL;
          default:   state_nxt = S_DSET;
        endcase
      end
      S_GMUL: begin
        unique case (g_ph)
          3'd0: begin
            mul_x = {g_k[31], g_k};
            mul_y = {{9{g_x[15]}}, g_x};
          end
          3'd2: begin
            mul_x = {1'b0, amag_r};
            mul_y = {1'b0, dmag_r[23:0]};
          end
          3'd3: begin
            mul_x = {1'b0, amag_r};
            mul_y = {1'b0, dmag_r[47:24]};
          end
          default: begin
          end
        endcase
        if (step_r == GMUL_LAST) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= (state_nxt != state_r) ? 7'd0 : step_r + 7'd1;
    end
  end

  always_ff @(posedge clk) begin
    mul_r <= mul_x * mul_y;
    rd_r  <= mem_r[slot];
    if (mem_we) begin
      mem_r[slot] <= '{norm_a: sum_aa_r, norm_b: sum_bb_r, dot: sum_ab_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      at_start_r <= 1'b1;
      sum_aa_r   <= '0;
      sum_bb_r   <= '0;
      sum_ab_r   <= '0;
      amag_r     <= '0;
      aneg_r     <= 1'b0;
      k1_r       <= '0;
      k2_r       <= '0;
      bwd_deg_r  <= 1'b0;
      fdeg_r     <= 1'b0;
      div_sel_r  <= DIV_COS;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            mode_r     <= in_ch.mode;
            sidx_r     <= in_ch.sample_index;
            idx_r      <= in_ch.sample_index;
            a_r        <= in_ch.feature_a;
            b_r        <= in_ch.feature_b;
            last_r     <= in_ch.last_element;
            g_r        <= in_ch.upstream_grad;
            start_r    <= at_start_r;
            at_start_r <= in_ch.last_element;
          end
        end
        S_SLOT: begin
          if (slot_hi) idx_r <= idx_r - 6'(MAX_SAMPLES);
        end
        S_MUL: begin
          unique case (step_r[1:0])
            2'd0: begin
              if (start_r) begin
                sum_aa_r <= '0;
                sum_bb_r <= '0;
                sum_ab_r <= '0;
              end
            end
            2'd1: sum_aa_r <= sat_add(sum_aa_r, mul_r);
            2'd2: sum_bb_r <= sat_add(sum_bb_r, mul_r);
            default: sum_ab_r <= sat_add(sum_ab_r, mul_r);
          endcase
        end
        S_FWD_END: begin
          n1_r      <= sum_aa_r;
          n2_r      <= sum_bb_r;
          d_r       <= sum_ab_r;
          rad_r     <= '0;
          fdeg_r    <= fwd_deg;
          div_sel_r <= DIV_COS;
        end
        S_RD: begin
        end
        S_LOAD: begin
          n1_r      <= rd_r.norm_a;
          n2_r      <= rd_r.norm_b;
          d_r       <= rd_r.dot;
          rad_r     <= '0;
          bwd_deg_r <= rd_deg;
          div_sel_r <= DIV_ALPHA;
        end
        S_PMUL: begin
          unique case (step_r[2:0])
            3'd1:    rad_r <= rad_r + RAD_W'(mul_r[SUM_W-1:0]);
            3'd2,
            3'd3:    rad_r <= rad_r + (RAD_W'(mul_r[SUM_W-1:0]) << 24);
            3'd4:    rad_r <= rad_r + (RAD_W'(mul_r[SUM_W-1:0]) << 48);
            default: begin
            end
          endcase
          rem_r  <= '0;
          root_r <= '0;
        end
        S_SQRT: begin
          rad_r  <= rad_r << 2;
          root_r <= {root_r[SUM_W-2:0], sub_ge};
          rem_r  <= sub_ge ? sub_full[SUM_W-1:0] : rem_sh_sq[SUM_W-1:0];
        end
        S_DSET: begin
          rem_r <= '0;
          q_r   <= '0;
          ovf_r <= 1'b0;
          unique case (div_sel_r)
            DIV_COS: begin
              num_r      <= {8'd0, d_mag, 16'd0};
              den_r      <= root_r;
              dneg_div_r <= 1'b0;
            end
            DIV_ALPHA: begin
              num_r      <= {16'd0, g_mag, 24'd0};
              den_r      <= root_r;
              dneg_div_r <= !g_r[31] && (g_r != '0);
            end
            DIV_K1: begin
              num_r      <= {d_mag, 24'd0};
              den_r      <= n1_r;
              dneg_div_r <= d_r[SUM_W-1];
            end
            default: begin
              num_r      <= {d_mag, 24'd0};
              den_r      <= n2_r;
              dneg_div_r <= d_r[SUM_W-1];
            end
          endcase
        end
        S_DIV: begin
          num_r <= num_r << 1;
          q_r   <= {q_r[QUO_W-2:0], sub_ge};
          ovf_r <= ovf_r | q_r[QUO_W-1];
          rem_r <= sub_ge ? sub_full[SUM_W-1:0] : rem_sh_dv[SUM_W-1:0];
        end
        S_DEND: begin
          unique case (div_sel_r)
            DIV_COS: begin
              dist_r <= d_r[SUM_W-1] ? ONE_Q16 + 18'(c_mag) : ONE_Q16 - 18'(c_mag);
            end
            DIV_ALPHA: begin
              aneg_r    <= q_fac[31];
              amag_r    <= q_fac[31] ? 32'(-q_fac) : 32'(q_fac);
              div_sel_r <= DIV_K1;
            end
            DIV_K1: begin
              k1_r      <= q_fac;
              div_sel_r <= DIV_K2;
            end
            default: k2_r <= q_fac;
          endcase
        end
        S_GMUL: begin
          unique case (g_ph)
            3'd0: begin
              if (!g_first) ga_r <= sat_q(acc_r[ACC_W-1:36], aneg_r ^ dneg_r);
            end
            3'd1: begin
              dneg_r <= g_diff[MUL_PW-1];
              dmag_r <= g_diff[MUL_PW-1] ? SUM_W'(-g_diff) : SUM_W'(g_diff);
            end
            3'd3: acc_r <= {22'd0, mul_r};
            3'd4: acc_r <= acc_r + {mul_r[55:0], 24'd0};
            3'd5: gb_r <= sat_q(acc_r[ACC_W-1:36], aneg_r ^ dneg_r);
            default: begin
            end
          endcase
        end
        S_DONE: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_kind_r <= mode_r;
      out_sidx_r <= sidx_r;
      out_last_r <= last_r;
      out_deg_r  <= mode_r ? bwd_deg_r : fdeg_r;
      out_dist_r <= (!mode_r && !fdeg_r) ? dist_r : '0;
      out_ga_r   <= (mode_r && !bwd_deg_r) ? ga_r : '0;
      out_gb_r   <= (mode_r && !bwd_deg_r) ? gb_r : '0;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.result_kind = out_kind_r;
  assign out_ch.sample_out  = out_sidx_r;
  assign out_ch.distance    = out_dist_r;
  assign out_ch.grad_a      = out_ga_r;
  assign out_ch.grad_b      = out_gb_r;
  assign out_ch.degenerate  = out_deg_r;
  assign out_ch.last_out    = out_last_r;

`ifndef NO_ASSERTIONS
  a_root_norms: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SQRT) |-> (!is_deg(n1_r, n2_r)))
    else $error("root taken over a zero norm");

  a_div_den: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (den_r != '0))
    else $error("divide by zero");

  a_grad_live: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_GMUL) |-> (mode_r && !bwd_deg_r))
    else $error("gradient pass on degenerate or forward transaction");

  a_done_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && out_valid_r && !out_ch.ready) |=> (state_r == S_DONE))
    else $error("result dropped while output stalled");
`endif

endmodule
